// File: sv/tamac_pkg.sv
`timescale 1ns / 1ps
// tamac_pkg: shared types and constants of the moving-average calibrator
// no dependencies; imported by the interfaces and by every module

package tamac_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int AXES       = 3;
    localparam int SCALE_FRAC = 12;
    localparam int ADDR_W     = 5;
    localparam int PDATA_W    = 32;

    typedef logic signed [SAMPLE_W-1:0]      smp_t;
    typedef logic        [SAMPLE_W-1:0]      scale_t;
    typedef logic        [AXES*SAMPLE_W-1:0] row_t;

    typedef enum logic
    {
        FUNC_SAMPLE    = 1'b0,
        FUNC_CAL_START = 1'b1
    } func_t;

    typedef enum logic [2:0]
    {
        REG_OFFSET_X = 3'd0,
        REG_OFFSET_Y = 3'd1,
        REG_OFFSET_Z = 3'd2,
        REG_SCALE_X  = 3'd3,
        REG_SCALE_Y  = 3'd4,
        REG_SCALE_Z  = 3'd5
    } reg_idx_t;

    // unity gain in q4.12
    localparam scale_t SCALE_ONE = scale_t'(1 << SCALE_FRAC);

endpackage

// File: sv/tamac_in_if.sv
`timescale 1ns / 1ps
// tamac_in_if: request channel carrying one sample triple or a calibration start
// depends on tamac_pkg

interface tamac_in_if;
    import tamac_pkg::*;

    logic valid;
    logic ready;
    logic func;
    smp_t sample_x;
    smp_t sample_y;
    smp_t sample_z;

    modport source (output valid, func, sample_x, sample_y, sample_z, input ready);
    modport sink   (input valid, func, sample_x, sample_y, sample_z, output ready);
endinterface

// File: sv/tamac_out_if.sv
`timescale 1ns / 1ps
// tamac_out_if: result channel with averages, corrected values and calibration extremes
// depends on tamac_pkg

interface tamac_out_if;
    import tamac_pkg::*;

    logic valid;
    logic ready;
    smp_t avg_x;
    smp_t avg_y;
    smp_t avg_z;
    smp_t corr_x;
    smp_t corr_y;
    smp_t corr_z;
    smp_t min_x;
    smp_t min_y;
    smp_t min_z;
    smp_t max_x;
    smp_t max_y;
    smp_t max_z;

    modport source (output valid, avg_x, avg_y, avg_z, corr_x, corr_y, corr_z,
                    min_x, min_y, min_z, max_x, max_y, max_z, input ready);
    modport sink   (input valid, avg_x, avg_y, avg_z, corr_x, corr_y, corr_z,
                    min_x, min_y, min_z, max_x, max_y, max_z, output ready);
endinterface

// File: sv/three_axis_moving_average_calibrator.sv
`timescale 1ns / 1ps
// three_axis_moving_average_calibrator: top level, pipeline control, state and config port
// depends on tamac_pkg, tamac_in_if, tamac_out_if, tamac_ring, tamac_div, tamac_corr
//
//  channel   dir  handshake             carries
//  samples   in   valid / ready         func, sample_x/y/z
//  results   out  valid / ready         avg, corr, min, max per axis
//  apb       in   psel/penable/pready   offsets and q4.12 scales, byte address 4*index
//
//  one request per cycle sustained while results are taken; the ring memory is read
//  and written once per sample request at the same address, so the running sum never waits
//  on the memory port; each request passes the ring, sum, divide, state update and
//  correction multiply stages, then the output register
//  no clearing pass after reset: per-entry valid bits make unwritten ring entries zero
//  a stalled result lets up to five more requests in before samples.ready drops

module three_axis_moving_average_calibrator #(
    parameter int WINDOW = 10
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tamac_pkg::ADDR_W-1:0]    paddr,
    input  logic [tamac_pkg::PDATA_W-1:0]   pwdata,
    output logic [tamac_pkg::PDATA_W-1:0]   prdata,
    output logic                            pready,
    tamac_in_if.sink                        samples,
    tamac_out_if.source                     results
);
    import tamac_pkg::*;

    localparam int SUM_W = SAMPLE_W + $clog2(WINDOW) + 1;
    localparam int PAD_W = PDATA_W - SAMPLE_W;

    // configuration registers
    smp_t   offset_reg [AXES];
    scale_t scale_reg  [AXES];
    logic   cfg_wr;
    reg_idx_t cfg_idx;

    // pipeline occupancy
    logic p1_vld_reg, p2_vld_reg, p3_vld_reg, p4_vld_reg, p5_vld_reg, out_vld_reg;
    logic p1_mv, p2_mv, p3_mv, p4_mv, p5_mv, out_free, in_rdy, accept;

    // request payload through the early stages
    func_t p1_func_reg, p2_func_reg, p3_func_reg;
    smp_t  p1_smp_reg [AXES];

    // block state
    logic signed [SUM_W-1:0] sum_reg  [AXES];
    logic signed [SUM_W-1:0] sum_next [AXES];
    smp_t avg_reg [AXES];
    smp_t min_reg [AXES];
    smp_t max_reg [AXES];
    logic cal_reg;

    // late stage payload and output register
    smp_t p5_avg_reg [AXES];
    smp_t p5_min_reg [AXES];
    smp_t p5_max_reg [AXES];
    smp_t out_avg_reg  [AXES];
    smp_t out_corr_reg [AXES];
    smp_t out_min_reg  [AXES];
    smp_t out_max_reg  [AXES];

    row_t wr_row;
    row_t old_row;
    smp_t div_avg  [AXES];
    smp_t corr_val [AXES];

    // ---------------------------------------------------------------- apb
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                offset_reg[a] <= '0;
                scale_reg[a]  <= SCALE_ONE;
            end
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_OFFSET_X: offset_reg[0] <= pwdata[SAMPLE_W-1:0];
                REG_OFFSET_Y: offset_reg[1] <= pwdata[SAMPLE_W-1:0];
                REG_OFFSET_Z: offset_reg[2] <= pwdata[SAMPLE_W-1:0];
                REG_SCALE_X:  scale_reg[0]  <= pwdata[SAMPLE_W-1:0];
                REG_SCALE_Y:  scale_reg[1]  <= pwdata[SAMPLE_W-1:0];
                REG_SCALE_Z:  scale_reg[2]  <= pwdata[SAMPLE_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_OFFSET_X: prdata = {{PAD_W{1'b0}}, offset_reg[0]};
            REG_OFFSET_Y: prdata = {{PAD_W{1'b0}}, offset_reg[1]};
            REG_OFFSET_Z: prdata = {{PAD_W{1'b0}}, offset_reg[2]};
            REG_SCALE_X:  prdata = {{PAD_W{1'b0}}, scale_reg[0]};
            REG_SCALE_Y:  prdata = {{PAD_W{1'b0}}, scale_reg[1]};
            REG_SCALE_Z:  prdata = {{PAD_W{1'b0}}, scale_reg[2]};
            default:      prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- flow control
    // each stage moves when the one after it is empty or moving itself
    always_comb
    begin
        out_free = !out_vld_reg || results.ready;
        p5_mv    = p5_vld_reg && out_free;
        p4_mv    = p4_vld_reg && (!p5_vld_reg || p5_mv);
        p3_mv    = p3_vld_reg && (!p4_vld_reg || p4_mv);
        p2_mv    = p2_vld_reg && (!p3_vld_reg || p3_mv);
        p1_mv    = p1_vld_reg && (!p2_vld_reg || p2_mv);
        in_rdy   = !p1_vld_reg || p1_mv;
        accept   = samples.valid && in_rdy;
    end

    assign samples.ready = in_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg  <= 1'b0;
            p2_vld_reg  <= 1'b0;
            p3_vld_reg  <= 1'b0;
            p4_vld_reg  <= 1'b0;
            p5_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                p1_vld_reg <= 1'b1;
            else if (p1_mv)
                p1_vld_reg <= 1'b0;
            if (p1_mv)
                p2_vld_reg <= 1'b1;
            else if (p2_mv)
                p2_vld_reg <= 1'b0;
            if (p2_mv)
                p3_vld_reg <= 1'b1;
            else if (p3_mv)
                p3_vld_reg <= 1'b0;
            if (p3_mv)
                p4_vld_reg <= 1'b1;
            else if (p4_mv)
                p4_vld_reg <= 1'b0;
            if (p4_mv)
                p5_vld_reg <= 1'b1;
            else if (p5_mv)
                p5_vld_reg <= 1'b0;
            if (p5_mv)
                out_vld_reg <= 1'b1;
            else if (results.ready)
                out_vld_reg <= 1'b0;
        end
    end

    // ---------------------------------------------------------------- stage 1: ring access
    // a calibration start leaves the ring and the write pointer alone
    assign wr_row = {samples.sample_z, samples.sample_y, samples.sample_x};

    tamac_ring #(
        .WINDOW (WINDOW)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept && (func_t'(samples.func) == FUNC_SAMPLE)),
        .wr_row  (wr_row),
        .old_row (old_row)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_func_reg   <= func_t'(samples.func);
            p1_smp_reg[0] <= samples.sample_x;
            p1_smp_reg[1] <= samples.sample_y;
            p1_smp_reg[2] <= samples.sample_z;
        end
        if (p1_mv)
            p2_func_reg <= p1_func_reg;
        if (p2_mv)
            p3_func_reg <= p2_func_reg;
    end

    // ---------------------------------------------------------------- stage 2: running sum
    // the sum register always belongs to the newest sample request that entered stage 2
    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            sum_next[a] = sum_reg[a]
                        - SUM_W'($signed(old_row[a*SAMPLE_W +: SAMPLE_W]))
                        + SUM_W'(p1_smp_reg[a]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < AXES; a++)
                sum_reg[a] <= '0;
        end
        else if (p1_mv && (p1_func_reg == FUNC_SAMPLE))
        begin
            for (int a = 0; a < AXES; a++)
                sum_reg[a] <= sum_next[a];
        end
    end

    // ---------------------------------------------------------------- stage 3: divide, stage 4: state
    // stage 5 correction multiply, per axis
    for (genvar g = 0; g < AXES; g++)
    begin : g_axis
        tamac_div #(
            .WINDOW (WINDOW)
        ) u_div (
            .clk (clk),
            .ld  (p2_mv),
            .sum (sum_reg[g]),
            .avg (div_avg[g])
        );

        tamac_corr u_corr (
            .clk    (clk),
            .ld     (p4_mv),
            .avg    (avg_reg[g]),
            .offset (offset_reg[g]),
            .scale  (scale_reg[g]),
            .corr   (corr_val[g])
        );
    end

    // averages, extremes and the calibration flag change only here, in request order;
    // stage 4 then reads them straight from these registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= 1'b0;
            for (int a = 0; a < AXES; a++)
            begin
                avg_reg[a] <= '0;
                min_reg[a] <= '0;
                max_reg[a] <= '0;
            end
        end
        else if (p3_mv)
        begin
            if (p3_func_reg == FUNC_CAL_START)
            begin
                cal_reg <= 1'b1;
                for (int a = 0; a < AXES; a++)
                begin
                    min_reg[a] <= '0;
                    max_reg[a] <= '0;
                end
            end
            else
            begin
                for (int a = 0; a < AXES; a++)
                begin
                    avg_reg[a] <= div_avg[a];
                    if (cal_reg && (div_avg[a] < min_reg[a]))
                        min_reg[a] <= div_avg[a];
                    if (cal_reg && (div_avg[a] > max_reg[a]))
                        max_reg[a] <= div_avg[a];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (p4_mv)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                p5_avg_reg[a] <= avg_reg[a];
                p5_min_reg[a] <= min_reg[a];
                p5_max_reg[a] <= max_reg[a];
            end
        end
        if (p5_mv)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                out_avg_reg[a]  <= p5_avg_reg[a];
                out_corr_reg[a] <= corr_val[a];
                out_min_reg[a]  <= p5_min_reg[a];
                out_max_reg[a]  <= p5_max_reg[a];
            end
        end
    end

    // ---------------------------------------------------------------- result channel
    assign results.valid  = out_vld_reg;
    assign results.avg_x  = out_avg_reg[0];
    assign results.avg_y  = out_avg_reg[1];
    assign results.avg_z  = out_avg_reg[2];
    assign results.corr_x = out_corr_reg[0];
    assign results.corr_y = out_corr_reg[1];
    assign results.corr_z = out_corr_reg[2];
    assign results.min_x  = out_min_reg[0];
    assign results.min_y  = out_min_reg[1];
    assign results.min_z  = out_min_reg[2];
    assign results.max_x  = out_max_reg[0];
    assign results.max_y  = out_max_reg[1];
    assign results.max_z  = out_max_reg[2];

    // ---------------------------------------------------------------- checks
    // calibration, once started, stays on
    a_cal_sticky : assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(cal_reg))
        else $error("calibration flag dropped");

    // extremes start at zero, so minima never go positive and maxima never negative
    a_extreme_sign : assert property (@(posedge clk) disable iff (!rst_n)
        (min_reg[0] <= 0) && (min_reg[1] <= 0) && (min_reg[2] <= 0) &&
        (max_reg[0] >= 0) && (max_reg[1] >= 0) && (max_reg[2] >= 0))
        else $error("calibration extreme on the wrong side of zero");

    // requests are refused only when every stage and the output register are full and the result is not taken
    a_no_bubble_stall : assert property (@(posedge clk) disable iff (!rst_n)
        !in_rdy |-> (p1_vld_reg && p2_vld_reg && p3_vld_reg && p4_vld_reg &&
                     p5_vld_reg && out_vld_reg && !results.ready))
        else $error("request refused with a free pipeline slot");

endmodule

// File: sv/tamac_ring.sv
`timescale 1ns / 1ps
// tamac_ring: sample window memory with write pointer and per-entry valid bits
// depends on tamac_pkg

module tamac_ring #(
    parameter int WINDOW = 10
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  tamac_pkg::row_t wr_row,
    output tamac_pkg::row_t old_row
);
    import tamac_pkg::*;

    localparam int            PW   = $clog2(WINDOW);
    localparam logic [PW-1:0] LAST = PW'(WINDOW - 1);

    row_t              mem [WINDOW];
    logic [WINDOW-1:0] vld_reg;
    logic [PW-1:0]     pos_reg;
    logic [PW-1:0]     pos_next;
    row_t              rd_reg;
    logic              rd_ok_reg;

    always_comb
    begin
        pos_next = (pos_reg == LAST) ? '0 : pos_reg + 1'b1;
    end

    // read-before-write: the evicted row comes out as the new one goes in
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[pos_reg] <= wr_row;
            rd_reg       <= mem[pos_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            vld_reg   <= '0;
            rd_ok_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            pos_reg          <= pos_next;
            vld_reg[pos_reg] <= 1'b1;
            rd_ok_reg        <= vld_reg[pos_reg];
        end
    end

    // never-written entries read as zero
    assign old_row = rd_ok_reg ? rd_reg : '0;

endmodule

// File: sv/tamac_div.sv
`timescale 1ns / 1ps
// tamac_div: window sum divided by the window length, truncated toward zero
// depends on tamac_pkg; reciprocal multiply, one register stage

module tamac_div #(
    parameter int WINDOW = 10,
    localparam int SUM_W = tamac_pkg::SAMPLE_W + $clog2(WINDOW) + 1
) (
    input  logic                    clk,
    input  logic                    ld,
    input  logic signed [SUM_W-1:0] sum,
    output tamac_pkg::smp_t         avg
);
    import tamac_pkg::*;

    localparam int L      = $clog2(WINDOW);
    localparam int ABS_W  = SAMPLE_W + L;
    localparam int SHIFT  = ABS_W + L;
    localparam int MUL_W  = ABS_W + 1;
    localparam int PROD_W = ABS_W + MUL_W;
    // ceil(2^SHIFT / WINDOW); error below 2^L keeps the quotient exact over ABS_W bits
    localparam logic [MUL_W-1:0] RECIP =
        MUL_W'(((longint'(1) << SHIFT) + longint'(WINDOW) - 1) / longint'(WINDOW));

    logic [SUM_W-1:0]    mag_w;
    logic [ABS_W-1:0]    mag;
    logic [PROD_W-1:0]   prod_reg;
    logic                neg_reg;
    logic [SAMPLE_W:0]   quo;
    logic [SAMPLE_W:0]   quo_s;

    always_comb
    begin
        mag_w = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
        mag   = mag_w[ABS_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            prod_reg <= mag * RECIP;
            neg_reg  <= sum[SUM_W-1];
        end
    end

    always_comb
    begin
        quo   = prod_reg[SHIFT +: SAMPLE_W+1];
        quo_s = neg_reg ? (~quo + 1'b1) : quo;
        avg   = quo_s[SAMPLE_W-1:0];
    end

endmodule

// File: sv/tamac_corr.sv
`timescale 1ns / 1ps
// tamac_corr: (average - offset) * q4.12 scale, floor shift and int16 saturation
// depends on tamac_pkg; product registered, shift and clamp after it

module tamac_corr (
    input  logic              clk,
    input  logic              ld,
    input  tamac_pkg::smp_t   avg,
    input  tamac_pkg::smp_t   offset,
    input  tamac_pkg::scale_t scale,
    output tamac_pkg::smp_t   corr
);
    import tamac_pkg::*;

    localparam int PROD_W = 2 * SAMPLE_W + 2;
    localparam int Q_W    = PROD_W - SCALE_FRAC;
    localparam logic signed [Q_W-1:0] QMAX = Q_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [Q_W-1:0] QMIN = Q_W'(-(1 << (SAMPLE_W - 1)));

    logic signed [SAMPLE_W:0]   diff;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [Q_W-1:0]      q;

    always_comb
    begin
        diff = $signed({avg[SAMPLE_W-1], avg}) - $signed({offset[SAMPLE_W-1], offset});
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            prod_reg <= diff * $signed({1'b0, scale});
        end
    end

    // dropping the fraction bits of a two's complement value floors it
    always_comb
    begin
        q = $signed(prod_reg[PROD_W-1:SCALE_FRAC]);
        if (q > QMAX)
        begin
            corr = QMAX[SAMPLE_W-1:0];
        end
        else if (q < QMIN)
        begin
            corr = QMIN[SAMPLE_W-1:0];
        end
        else
        begin
            corr = q[SAMPLE_W-1:0];
        end
    end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for three_axis_moving_average_calibrator, with its own
// window/calibration/correction predictor, random gaps and stalls and apb register sweeps
// depends on tamac_pkg, tamac_in_if, tamac_out_if and the calibrator rtl

module testbench;
    import tamac_pkg::*;

    localparam int WINDOW     = 10;
    localparam int REG_COUNT  = 6;      // offset x/y/z then scale x/y/z
    localparam int REG_STRIDE = 4;      // byte stride of the apb register map
    localparam int GAP_PCT    = 38;     // idle share in percent on each side
    localparam int ERR_QUIET  = 100;    // stop printing after this many failures

    // result groups, in the order avg, corr, min, max
    localparam int GRP_AVG  = 0;
    localparam int GRP_CORR = 1;
    localparam int GRP_MIN  = 2;
    localparam int GRP_MAX  = 3;
    localparam int GROUPS   = 4;

    typedef smp_t [GROUPS-1:0][AXES-1:0] result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    tamac_in_if  smp_if ();
    tamac_out_if res_if ();

    three_axis_moving_average_calibrator #(
        .WINDOW  (WINDOW)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .samples (smp_if),
        .results (res_if)
    );

    // ------------------------------------------------------------------
    // predictor state: a private copy of the ring, averages, extremes and registers
    // ------------------------------------------------------------------
    smp_t        ring_mem [WINDOW][AXES];
    int unsigned ring_wr;
    smp_t        avg_r [AXES];
    smp_t        min_r [AXES];
    smp_t        max_r [AXES];
    bit          cal_on;
    smp_t        off_r  [AXES];
    scale_t      gain_r [AXES];

    result_t     calibrated_q [$];   // results still owed by the block, oldest first
    int          err_count;
    bit          no_gaps;            // both sides run flat out while set
    smp_t        drift [AXES];       // slowly wandering centre for realistic samples

    string axis_tag  [AXES]   = '{"x", "y", "z"};
    string group_tag [GROUPS] = '{"avg", "corr", "min", "max"};

    function automatic void clear_model();
        foreach (ring_mem[i, a])
            ring_mem[i][a] = '0;
        ring_wr = 0;
        cal_on  = 1'b0;
        for (int a = 0; a < AXES; a++)
        begin
            avg_r[a]  = '0;
            min_r[a]  = '0;
            max_r[a]  = '0;
            off_r[a]  = '0;
            gain_r[a] = SCALE_ONE;
            drift[a]  = '0;
        end
    endfunction

    // (average - offset) * q4.12 gain, floored by the arithmetic shift, then clamped
    function automatic smp_t corrected(smp_t avg, smp_t off, scale_t gain);
        longint diff;
        longint prod;
        longint q;
        diff = longint'(avg) - longint'(off);
        prod = diff * longint'(gain);
        q    = prod >>> SCALE_FRAC;
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return smp_t'(q);
    endfunction

    // advance the predictor by one accepted request and return what the block owes
    function automatic result_t next_calibrated_result(func_t f, smp_t sx, smp_t sy, smp_t sz);
        result_t r;
        smp_t    s_in [AXES];
        int      sum;
        s_in = '{sx, sy, sz};
        if (f == FUNC_CAL_START)
        begin
            // sample fields are ignored, extremes restart from zero
            cal_on = 1'b1;
            for (int a = 0; a < AXES; a++)
            begin
                min_r[a] = '0;
                max_r[a] = '0;
            end
        end
        else
        begin
            for (int a = 0; a < AXES; a++)
                ring_mem[ring_wr][a] = s_in[a];
            ring_wr = (ring_wr + 1) % WINDOW;
            for (int a = 0; a < AXES; a++)
            begin
                sum = 0;
                for (int i = 0; i < WINDOW; i++)
                    sum += ring_mem[i][a];
                // int division truncates toward zero, as the block does
                avg_r[a] = smp_t'(sum / WINDOW);
                if (cal_on)
                begin
                    if (avg_r[a] < min_r[a])
                        min_r[a] = avg_r[a];
                    if (avg_r[a] > max_r[a])
                        max_r[a] = avg_r[a];
                end
            end
        end
        for (int a = 0; a < AXES; a++)
        begin
            r[GRP_AVG][a]  = avg_r[a];
            r[GRP_CORR][a] = corrected(avg_r[a], off_r[a], gain_r[a]);
            r[GRP_MIN][a]  = min_r[a];
            r[GRP_MAX][a]  = max_r[a];
        end
        return r;
    endfunction

    function automatic logic [SAMPLE_W-1:0] reg_value(int idx);
        if (idx <= REG_OFFSET_Z)
            return off_r[idx];
        return gain_r[idx - REG_SCALE_X];
    endfunction

    function automatic void note_failure();
        err_count++;
    endfunction

    // ------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // result side: random stalls, and every accepted result checked against the
    // oldest prediction, field by field
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        result_t want;
        result_t got;
        if (res_if.valid === 1'b1 && res_if.ready === 1'b1)
        begin
            got[GRP_AVG]  = {res_if.avg_z,  res_if.avg_y,  res_if.avg_x};
            got[GRP_CORR] = {res_if.corr_z, res_if.corr_y, res_if.corr_x};
            got[GRP_MIN]  = {res_if.min_z,  res_if.min_y,  res_if.min_x};
            got[GRP_MAX]  = {res_if.max_z,  res_if.max_y,  res_if.max_x};
            if (calibrated_q.size() == 0)
            begin
                note_failure();
                if (err_count <= ERR_QUIET)
                    $error("result with no request outstanding");
            end
            else
            begin
                want = calibrated_q.pop_front();
                for (int g = 0; g < GROUPS; g++)
                    for (int a = 0; a < AXES; a++)
                        if (got[g][a] !== want[g][a])
                        begin
                            note_failure();
                            if (err_count <= ERR_QUIET)
                                $error("%s_%s: expected %0d, got %0d", group_tag[g],
                                       axis_tag[a], $signed(want[g][a]), $signed(got[g][a]));
                        end
            end
        end
        res_if.ready <= no_gaps || ($urandom_range(99) >= GAP_PCT);
    end

    // ------------------------------------------------------------------
    // request side; every task starts and ends just after a rising edge
    // ------------------------------------------------------------------
    task automatic send_request(func_t f, smp_t sx, smp_t sy, smp_t sz);
        while (!no_gaps && $urandom_range(99) < GAP_PCT)
        begin
            smp_if.valid <= 1'b0;
            @(posedge clk);
        end
        smp_if.valid    <= 1'b1;
        smp_if.func     <= f;
        smp_if.sample_x <= sx;
        smp_if.sample_y <= sy;
        smp_if.sample_z <= sz;
        do
            @(posedge clk);
        while (smp_if.ready !== 1'b1);
        calibrated_q.push_back(next_calibrated_result(f, sx, sy, sz));
    endtask

    // hold off new requests until the block has handed back everything it owes
    task automatic drain_results();
        while (calibrated_q.size() != 0)
        begin
            smp_if.valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic write_reg(int idx, logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * REG_STRIDE);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        // indexes past the register list are dropped by the block
        if (idx <= REG_OFFSET_Z)
            off_r[idx] = value[SAMPLE_W-1:0];
        else if (idx <= REG_SCALE_Z)
            gain_r[idx - REG_SCALE_X] = value[SAMPLE_W-1:0];
    endtask

    task automatic check_reg(int idx);
        logic [PDATA_W-1:0] data;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_W'(idx * REG_STRIDE);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (data[SAMPLE_W-1:0] !== reg_value(idx))
        begin
            note_failure();
            if (err_count <= ERR_QUIET)
                $error("reg %0d readback: expected %h, got %h", idx, reg_value(idx),
                       data[SAMPLE_W-1:0]);
        end
    endtask

    task automatic check_all_regs();
        for (int i = 0; i < REG_COUNT; i++)
            check_reg(i);
    endtask

    // one axis value: mostly near a wandering centre so the window average moves
    // about, some full range, some pinned at the extremes, at minus one or at zero
    function automatic smp_t pick_sample(int a);
        int pick;
        int v;
        pick = $urandom_range(99);
        v = int'(drift[a]) + int'($urandom_range(400)) - 200;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        drift[a] = smp_t'(v);
        if (pick < 60)
        begin
            v = int'(drift[a]) + int'($urandom_range(1024)) - 512;
            if (v > 32767)
                v = 32767;
            if (v < -32768)
                v = -32768;
            return smp_t'(v);
        end
        if (pick < 85)
            return smp_t'($urandom);
        case ($urandom_range(3))
            0:       return smp_t'(16'h7fff);
            1:       return smp_t'(16'h8000);
            2:       return smp_t'(16'hffff);
            default: return smp_t'(16'h0000);
        endcase
    endfunction

    // random stream; calibration restarts now and then, the ignored sample fields
    // of a restart still carry random data
    task automatic random_requests(int count, int flat_out, bit mid_pause);
        func_t f;
        for (int n = 0; n < count; n++)
        begin
            no_gaps = (n < flat_out);
            if (mid_pause && n == count / 2)
                drain_results();
            f = ($urandom_range(49) == 0) ? FUNC_CAL_START : FUNC_SAMPLE;
            send_request(f, pick_sample(0), pick_sample(1), pick_sample(2));
        end
        no_gaps = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset values, then the ring filled with the extremes on x and y and with 0x5555
    // then 0xaaaa on z, so the averages swing while calibration follows them
    task automatic test_window_extremes();
        check_all_regs();
        send_request(FUNC_SAMPLE, '0, '0, '0);
        send_request(FUNC_CAL_START, smp_t'(16'h1234), smp_t'(16'h8001), smp_t'(16'h7ffe));
        for (int i = 0; i < WINDOW; i++)
            send_request(FUNC_SAMPLE, smp_t'(16'h7fff), smp_t'(16'h8000), smp_t'(16'h5555));
        for (int i = 0; i < WINDOW; i++)
            send_request(FUNC_SAMPLE, smp_t'(16'h8000), smp_t'(16'h7fff), smp_t'(16'haaaa));
    endtask

    // a second start clears the extremes but leaves the ring and averages alone;
    // there is no way to stop calibrating, so the next sample still updates them
    task automatic test_cal_restart();
        send_request(FUNC_CAL_START, smp_t'(16'hffff), smp_t'(16'h0001), smp_t'(16'h8000));
        send_request(FUNC_SAMPLE, smp_t'(16'h0007), smp_t'(16'hfff9), smp_t'(16'h0000));
        drain_results();
    endtask

    // unity gain and zero offset from reset; a flat-out stretch first, and one
    // pause in the middle until every result is back
    task automatic test_unity_stream();
        random_requests(400, 150, 1'b1);
        drain_results();
    endtask

    // register extremes that push the corrected value into saturation both ways,
    // plus a zero gain
    task automatic test_saturation();
        write_reg(REG_OFFSET_X, 32'h0000_7fff);
        write_reg(REG_OFFSET_Y, 32'hffff_8000);
        write_reg(REG_OFFSET_Z, 32'h0000_0000);
        write_reg(REG_SCALE_X, 32'h0000_ffff);
        write_reg(REG_SCALE_Y, 32'h0000_ffff);
        write_reg(REG_SCALE_Z, 32'h0000_ffff);
        check_all_regs();
        random_requests(150, 0, 1'b0);
        drain_results();
        write_reg(REG_OFFSET_X, 32'hffff_8000);
        write_reg(REG_OFFSET_Y, 32'h0000_7fff);
        write_reg(REG_OFFSET_Z, 32'hffff_ffff);
        write_reg(REG_SCALE_X, 32'h0000_0000);
        write_reg(REG_SCALE_Y, 32'h0000_ffff);
        write_reg(REG_SCALE_Z, 32'h0000_0001);
        check_all_regs();
        random_requests(150, 0, 1'b0);
        drain_results();
    endtask

    // writes past the register list must leave the map untouched, then random
    // offsets and gains, mostly below twice unity so the output does not just clamp
    task automatic test_random_gains();
        for (int round = 0; round < 2; round++)
        begin
            write_reg(REG_COUNT, $urandom);
            write_reg(REG_COUNT + 1, $urandom);
            check_all_regs();
            for (int i = REG_OFFSET_X; i <= REG_OFFSET_Z; i++)
                write_reg(i, $urandom);
            for (int i = REG_SCALE_X; i <= REG_SCALE_Z; i++)
                write_reg(i, ($urandom_range(3) == 0) ? $urandom : $urandom_range(8191));
            check_all_regs();
            random_requests(250, 0, 1'b0);
            drain_results();
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        smp_if.valid    = 1'b0;
        smp_if.func     = FUNC_SAMPLE;
        smp_if.sample_x = '0;
        smp_if.sample_y = '0;
        smp_if.sample_z = '0;
        res_if.ready    = 1'b0;
        err_count       = 0;
        no_gaps         = 1'b0;
        clear_model();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_window_extremes();
        test_cal_restart();
        test_unity_stream();
        test_saturation();
        test_random_gains();

        // five-stage pipeline, so a short settle catches any stray result
        drain_results();
        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("testbench: errors");
        $finish;
    end

endmodule
